// File: src/dcs_pkg.sv
// shared constants, codes and types for the discrete cdf sampler
package dcs_pkg;

   localparam int MAX_BINS  = 1024;
   localparam int ADDR_W    = $clog2(MAX_BINS);
   localparam int CNT_W     = 11;
   localparam int ENTRY_W   = 58;
   localparam int FRAC_W    = 32;
   localparam int LOAD_W    = 24;
   localparam int LPROD_W   = 2 * LOAD_W;
   localparam int SCALED_W  = ENTRY_W + FRAC_W;
   localparam int T_HI_W    = ENTRY_W - FRAC_W;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_SAMPLE  = 2'd1,
      OP_UNIFORM = 2'd2
   } op_type;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_W-1:0]    wr_addr;
      logic [ENTRY_W-1:0]   wr_data;
      logic                 rd_en;
      logic [ADDR_W-1:0]    rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic lo_en;
      logic hi_en;
      logic sum_en;
   } mul_ctl_type;

endpackage

// File: src/dcs_table_ram.sv
// cumulative weight table, one write and one registered read port
module dcs_table_ram
   import dcs_pkg::*;
(
   input  logic                clock,
   input  ram_req_type         ram_req,
   output logic [ENTRY_W-1:0]  rd_data
);

   logic [ENTRY_W-1:0] mem [MAX_BINS];

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data <= mem[ram_req.rd_addr];
      end
   end

endmodule

// File: src/dcs_scale_mul.sv
// z times total in two partial products and a final add
module dcs_scale_mul
   import dcs_pkg::*;
(
   input  logic                 clock,
   input  mul_ctl_type          mul_ctl,
   input  logic [FRAC_W-1:0]    z,
   input  logic [ENTRY_W-1:0]   total,
   output logic [SCALED_W-1:0]  product
);

   logic [2*FRAC_W-1:0]        p0_ff;
   logic [FRAC_W+T_HI_W-1:0]   p1_ff;
   logic [SCALED_W-1:0]        product_ff;

   always_ff @(posedge clock) begin
      if (mul_ctl.lo_en) begin
         p0_ff <= z * total[FRAC_W-1:0];
      end
      if (mul_ctl.hi_en) begin
         p1_ff <= z * total[ENTRY_W-1:FRAC_W];
      end
      if (mul_ctl.sum_en) begin
         product_ff <= SCALED_W'(p0_ff) + {p1_ff, {FRAC_W{1'b0}}};
      end
   end

   assign product = product_ff;

endmodule

// File: src/discrete_cdf_sampler_core.sv
// top level: sequencer for load, uniform fill and binary-search sampling
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_stall  operation weight factor fraction count
//   rsp       out         rsp_valid/rsp_stall  bin_index
//   csr       in          csr_wr_en            csr_wr_data (bins_in_use)
//
// after reset a clearing pass writes every one of the 1024 table entries
// with req_stall high; csr writes are taken during it.
// load: one table write. uniform: one table write a cycle, entries 0 to bins_in_use - 1.
// sample: total read, two partial products, a wide add, the end checks, then one table
// read per search step (at most 10), before the result goes to the output register.
// the result waits in an output register, so a stalled rsp side holds only samples.
module discrete_cdf_sampler_core
   import dcs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_operation,
   input  logic [LOAD_W-1:0]    req_weight,
   input  logic [LOAD_W-1:0]    req_factor,
   input  logic [FRAC_W-1:0]    req_uniform_fraction,
   input  logic [CNT_W-1:0]     req_uniform_count,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ADDR_W-1:0]    rsp_bin_index,
   input  logic                 csr_wr_en,
   input  logic [CNT_W-1:0]     csr_wr_data
);

   typedef enum logic [10:0] {
      S_CLR  = 11'b000_0000_0001,
      S_IDLE = 11'b000_0000_0010,
      S_LADD = 11'b000_0000_0100,
      S_UNI  = 11'b000_0000_1000,
      S_TOT  = 11'b000_0001_0000,
      S_MUL0 = 11'b000_0010_0000,
      S_MUL1 = 11'b000_0100_0000,
      S_SUM  = 11'b000_1000_0000,
      S_CHK  = 11'b001_0000_0000,
      S_SRCH = 11'b010_0000_0000,
      S_DONE = 11'b100_0000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]      rsp_bin_ff, rsp_bin_in;
   logic [CNT_W-1:0]       bins_ff, bins_in;
   logic [ADDR_W-1:0]      ptr_ff, ptr_in;
   logic [ENTRY_W-1:0]     total_run_ff, total_run_in;
   logic [ADDR_W-1:0]      idx_ff, idx_in;
   logic [LPROD_W-1:0]     lprod_ff, lprod_in;
   logic [CNT_W-1:0]       ucount_ff, ucount_in;
   logic [FRAC_W-1:0]      z_ff, z_in;
   logic [ENTRY_W-1:0]     t_ff, t_in;
   logic                   zflag_ff, zflag_in;
   logic [ADDR_W-1:0]      lo_ff, lo_in;
   logic [ADDR_W-1:0]      hi_ff, hi_in;
   logic [ADDR_W-1:0]      res_ff, res_in;

   ram_req_type            ram_req;
   mul_ctl_type            mul_ctl;
   logic [ENTRY_W-1:0]     rd_data;
   logic [SCALED_W-1:0]    product;

   logic [ADDR_W-1:0]      last_bin;
   logic                   out_free;
   logic [CNT_W-1:0]       csr_val;
   logic [ENTRY_W:0]       load_sum;
   logic [ENTRY_W-1:0]     load_base;
   logic [ENTRY_W-1:0]     load_val;
   logic [CNT_W-1:0]       ptr_next;
   logic [CNT_W-1:0]       idx_plus;
   logic [ENTRY_W-1:0]     uni_val;
   logic [ENTRY_W-1:0]     entry;
   logic [ADDR_W-1:0]      lo_n, hi_n, diff_n, mid_n;
   logic [ADDR_W:0]        mid_sum;
   logic                   le;

   dcs_table_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   dcs_scale_mul u_mul (
      .clock   (clock),
      .mul_ctl (mul_ctl),
      .z       (z_ff),
      .total   (t_ff),
      .product (product)
   );

   assign last_bin  = ADDR_W'(bins_ff - CNT_W'(1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_bin_index = rsp_bin_ff;

   always_comb begin
      csr_val = csr_wr_data;
      if (csr_val == '0) begin
         csr_val = CNT_W'(1);
      end else if (csr_val > CNT_W'(MAX_BINS)) begin
         csr_val = CNT_W'(MAX_BINS);
      end
   end

   assign load_base = (ptr_ff == '0) ? '0 : total_run_ff;
   assign load_sum  = {1'b0, load_base} + (ENTRY_W+1)'(lprod_ff);
   assign load_val  = load_sum[ENTRY_W] ? {ENTRY_W{1'b1}} : load_sum[ENTRY_W-1:0];
   assign ptr_next  = {1'b0, ptr_ff} + CNT_W'(1);
   assign idx_plus  = {1'b0, idx_ff} + CNT_W'(1);
   assign uni_val   = ({1'b0, idx_ff} < ucount_ff) ? ENTRY_W'(idx_plus)
                                                   : ENTRY_W'(ucount_ff);

   assign entry   = zflag_ff ? ENTRY_W'(idx_ff) : rd_data;
   assign le      = ({entry, {FRAC_W{1'b0}}} <= product);
   assign lo_n    = le ? idx_ff : lo_ff;
   assign hi_n    = le ? hi_ff : idx_ff;
   assign diff_n  = hi_n - lo_n;
   assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
   assign mid_n   = mid_sum[ADDR_W:1];

   always_comb begin
      logic [ADDR_W:0] mid0;
      mid0 = {1'b0, last_bin};
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_bin_in   = rsp_bin_ff;
      bins_in      = csr_wr_en ? csr_val : bins_ff;
      ptr_in       = ptr_ff;
      total_run_in = total_run_ff;
      idx_in       = idx_ff;
      lprod_in     = lprod_ff;
      ucount_in    = ucount_ff;
      z_in         = z_ff;
      t_in         = t_ff;
      zflag_in     = zflag_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      res_in       = res_ff;
      ram_req      = '0;
      mul_ctl      = '0;

      case (state_ff)
         S_CLR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = idx_ff;
            ram_req.wr_data = ENTRY_W'(1);
            idx_in          = idx_ff + ADDR_W'(1);
            if (idx_ff == ADDR_W'(MAX_BINS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               case (req_operation)
                  OP_LOAD: begin
                     lprod_in = req_weight * req_factor;
                     if ({1'b0, ptr_ff} >= bins_ff) begin
                        ptr_in = '0;
                     end
                     state_in = S_LADD;
                  end
                  OP_SAMPLE: begin
                     z_in = req_uniform_fraction;
                     if (bins_ff == CNT_W'(1)) begin
                        res_in   = '0;
                        state_in = S_DONE;
                     end else begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = last_bin;
                        state_in        = S_TOT;
                     end
                  end
                  OP_UNIFORM: begin
                     ucount_in = req_uniform_count;
                     idx_in    = '0;
                     state_in  = S_UNI;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_LADD: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = ptr_ff;
            ram_req.wr_data = load_val;
            total_run_in    = load_val;
            ptr_in          = (ptr_next >= bins_ff) ? '0 : ptr_next[ADDR_W-1:0];
            state_in        = S_IDLE;
         end
         S_UNI: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = idx_ff;
            ram_req.wr_data = uni_val;
            idx_in          = idx_ff + ADDR_W'(1);
            if (idx_ff == last_bin) begin
               total_run_in = uni_val;
               ptr_in       = '0;
               state_in     = S_IDLE;
            end
         end
         S_TOT: begin
            zflag_in = (rd_data == '0);
            t_in     = (rd_data == '0) ? ENTRY_W'(last_bin) : rd_data;
            state_in = S_MUL0;
         end
         S_MUL0: begin
            mul_ctl.lo_en = 1'b1;
            state_in      = S_MUL1;
         end
         S_MUL1: begin
            mul_ctl.hi_en   = 1'b1;
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = '0;
            state_in        = S_SUM;
         end
         S_SUM: begin
            mul_ctl.sum_en = 1'b1;
            state_in       = S_CHK;
         end
         S_CHK: begin
            if ({t_ff, {FRAC_W{1'b0}}} < product) begin
               res_in   = last_bin;
               state_in = S_DONE;
            end else if ({(zflag_ff ? ENTRY_W'(0) : rd_data), {FRAC_W{1'b0}}} > product)
            begin
               res_in   = '0;
               state_in = S_DONE;
            end else if (last_bin == ADDR_W'(1)) begin
               res_in   = last_bin;
               state_in = S_DONE;
            end else begin
               lo_in           = '0;
               hi_in           = last_bin;
               idx_in          = mid0[ADDR_W:1];
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = mid0[ADDR_W:1];
               state_in        = S_SRCH;
            end
         end
         S_SRCH: begin
            lo_in = lo_n;
            hi_in = hi_n;
            if (|diff_n[ADDR_W-1:1]) begin
               idx_in          = mid_n;
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = mid_n;
            end else begin
               res_in   = hi_n;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_bin_in   = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         rsp_valid_ff <= 1'b0;
         bins_ff      <= CNT_W'(MAX_BINS);
         ptr_ff       <= '0;
         total_run_ff <= ENTRY_W'(1);
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bins_ff      <= bins_in;
         ptr_ff       <= ptr_in;
         total_run_ff <= total_run_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_bin_ff <= rsp_bin_in;
      lprod_ff   <= lprod_in;
      ucount_ff  <= ucount_in;
      z_ff       <= z_in;
      t_ff       <= t_in;
      zflag_ff   <= zflag_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      res_ff     <= res_in;
   end

endmodule
